/* rtl/ngs_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package ngs_pkg;

  localparam int STACK_DEPTH_DEFAULT = 32;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NONE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Which fields a result takes
  typedef enum logic [1:0] {
    EMIT_PAIR,
    EMIT_OVERFLOW,
    EMIT_FLUSH
  } emit_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    logic       emit;
    emit_kind_t kind;
    logic       run_end;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic top_lt;
    logic more_pop;
    logic full;
    logic count_one;
    logic last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/ngs_datapath.sv */
// Stack memory, top-of-stack register, item registers and output register.
module ngs_datapath #(
  parameter int STACK_DEPTH = ngs_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ngs_pkg::cmd_t       cmd,
  output ngs_pkg::stat_t      stat,
  input  logic signed [31:0]  value,
  input  logic                last_value,
  output logic signed [31:0]  element,
  output logic signed [31:0]  greater,
  output logic [1:0]          status,
  output logic                run_end,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] rd_data;
  logic signed [31:0] cur_value;
  logic               cur_last;
  logic signed [31:0] top;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               count_ge2;

  // Entry just below the top; only used when two or more are stacked
  assign count_ge2 = (count >= CW'(2));
  assign rd_addr   = count_ge2 ? AW'(count - CW'(2)) : '0;
  assign wr_addr   = AW'(count);

  always_comb begin
    stat.top_lt    = (count != '0) && (top < cur_value);
    stat.more_pop  = count_ge2 && (rd_data < cur_value);
    stat.full      = (count == CW'(STACK_DEPTH));
    stat.count_one = (count == CW'(1));
    stat.last      = cur_last;
    stat.out_free  = !out_valid || out_ready;
  end

  // Stack memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cur_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Item registers and top of stack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_value <= value;
      cur_last  <= last_value;
    end
    if (cmd.push) begin
      top <= cur_value;
    end else if (cmd.pop) begin
      top <= rd_data;
    end
  end

  // Stack fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      count <= count - CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_end <= cmd.run_end;
      unique case (cmd.kind)
        ngs_pkg::EMIT_PAIR: begin
          element <= top;
          greater <= cur_value;
          status  <= ngs_pkg::STATUS_FOUND;
        end
        ngs_pkg::EMIT_OVERFLOW: begin
          element <= cur_value;
          greater <= '0;
          status  <= ngs_pkg::STATUS_OVERFLOW;
        end
        default: begin
          element <= top;
          greater <= '0;
          status  <= ngs_pkg::STATUS_NONE;
        end
      endcase
    end
  end

endmodule

/* rtl/ngs_controller.sv */
// Sequencer for compare, pop, push, overflow and flush steps.
module ngs_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ngs_pkg::stat_t stat,
  output ngs_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CMP,
    POP,
    FLUSH,
    FEMIT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '0;
    cmd.kind   = ngs_pkg::EMIT_PAIR;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = CMP;
        end
      end
      CMP: begin
        if (stat.top_lt) begin
          state_next = POP;
        end else if (stat.full) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.kind    = ngs_pkg::EMIT_OVERFLOW;
            cmd.run_end = !stat.last;
            state_next  = stat.last ? FLUSH : IDLE;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = stat.last ? FLUSH : IDLE;
        end
      end
      POP: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = ngs_pkg::EMIT_PAIR;
          cmd.run_end = !stat.more_pop && !stat.last;
          cmd.pop     = 1'b1;
          state_next  = CMP;
        end
      end
      FLUSH: begin
        state_next = FEMIT;
      end
      FEMIT: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = ngs_pkg::EMIT_FLUSH;
          cmd.run_end = stat.count_one;
          cmd.pop     = 1'b1;
          state_next  = stat.count_one ? IDLE : FLUSH;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/next_greater_element_stack_unit.sv */
// Top level of the next-greater-element monotonic stack unit.
// Values are taken one at a time; the unit accepts a new value only when
// the previous one is fully processed, though a finished result may still
// sit in the output register. An item passes through an accept step, a
// compare and then a pop step for each value it pops (the pop uses a
// registered read of the entry below the top), and a final compare that
// pushes the value or emits an overflow result; a last item then adds a
// flush and an emit step per flushed entry. Steps that emit a result wait
// while the output register still holds an untaken result.
module next_greater_element_stack_unit #(
  parameter int STACK_DEPTH = ngs_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               last_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] element,
  output logic signed [31:0] greater,
  output logic [1:0]         status,
  output logic               run_end
);

  ngs_pkg::cmd_t  cmd;
  ngs_pkg::stat_t stat;

  ngs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ngs_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .value      (value),
    .last_value (last_value),
    .element    (element),
    .greater    (greater),
    .status     (status),
    .run_end    (run_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  // One item at a time: no accept in the cycle after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Only defined status codes leave the unit
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ngs_pkg::STATUS_FOUND || status == ngs_pkg::STATUS_NONE ||
                   status == ngs_pkg::STATUS_OVERFLOW))
    else $error("undefined status code");

  // Greater is zero unless a greater value was found
  a_greater_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ngs_pkg::STATUS_FOUND) |-> (greater == '0))
    else $error("nonzero greater on a result without a match");

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written over an untaken result");

endmodule

/* verif/tb_next_greater_element_stack_unit.sv */
// Testbench for the next-greater-element stack unit: directed table, random runs, scoreboard.
module tb_next_greater_element_stack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ngs_pkg::STACK_DEPTH_DEFAULT;
  localparam int TOTAL_ITEMS = 360;
  localparam int DIR_ROWS = 15;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] element;
    logic signed [31:0] greater;
    logic [1:0]         status;
    logic               run_end;
  } result_t;

  // One directed row; reps > 1 repeats the same value, typed rows carry
  // their single expected result inline
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic [7:0]         reps;
    logic               typed;
    logic signed [31:0] exp_element;
    logic [1:0]         exp_status;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] value;
  logic               last_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] element;
  logic signed [31:0] greater;
  logic [1:0]         status;
  logic               run_end;

  // Predictor state: mirror of the monotonic stack
  logic signed [31:0] nge_stack [DEPTH];
  int                 nge_depth;

  result_t  step_results [$];
  result_t  pending_results [$];
  dir_row_t dir_rows [DIR_ROWS];

  bit gaps_on;
  bit timed_out;
  int mismatches = 0;
  int items_sent;
  int results_seen = 0;
  int pairs_seen = 0;
  int flushes_seen = 0;
  int overflows_seen = 0;
  logic signed [31:0] prev_value;

  next_greater_element_stack_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .last_value (last_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .element    (element),
    .greater    (greater),
    .status     (status),
    .run_end    (run_end)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Compute the results one value causes and advance the stack mirror
  task automatic resolve_value(input logic signed [31:0] v, input logic l);
    result_t r;
    step_results.delete();
    while (nge_depth > 0 && nge_stack[nge_depth-1] < v) begin
      r = '{element: nge_stack[nge_depth-1], greater: v, status: ngs_pkg::STATUS_FOUND,
            run_end: 1'b0};
      step_results.push_back(r);
      nge_depth--;
    end
    if (nge_depth >= DEPTH) begin
      r = '{element: v, greater: 32'sd0, status: ngs_pkg::STATUS_OVERFLOW, run_end: 1'b0};
      step_results.push_back(r);
    end else begin
      nge_stack[nge_depth] = v;
      nge_depth++;
    end
    if (l) begin
      while (nge_depth > 0) begin
        nge_depth--;
        r = '{element: nge_stack[nge_depth], greater: 32'sd0, status: ngs_pkg::STATUS_NONE,
              run_end: 1'b0};
        step_results.push_back(r);
      end
    end
    if (step_results.size() > 0)
      step_results[step_results.size()-1].run_end = 1'b1;
  endtask

  // Drive one value, wait for its transfer, then record what it should cause
  task automatic transfer_value(input logic signed [31:0] v, input logic l,
                                input logic typed, input result_t typed_result);
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 33) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    last_value <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    resolve_value(v, l);
    if (typed)
      pending_results.push_back(typed_result);
    else
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // Random value: small range for ties, full range, or an extreme
  function automatic logic signed [31:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $signed(32'($urandom_range(0, 16))) - 32'sd8;
    if (kind < 8) return $signed($urandom);
    case ($urandom_range(0, 5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return VAL_MIN + 32'sd1;
      default: return VAL_MAX - 32'sd1;
    endcase
  endfunction

  // Sink side: random back-pressure plus the scoreboard check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      case (status)
        ngs_pkg::STATUS_FOUND:    pairs_seen++;
        ngs_pkg::STATUS_NONE:     flushes_seen++;
        ngs_pkg::STATUS_OVERFLOW: overflows_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result element=%0d greater=%0d status=%0d run_end=%0b",
                   element, greater, status, run_end);
      end else begin
        if (element !== pending_results[0].element || greater !== pending_results[0].greater ||
            status !== pending_results[0].status || run_end !== pending_results[0].run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                     results_seen, pending_results[0].element, pending_results[0].greater,
                     pending_results[0].status, pending_results[0].run_end,
                     element, greater, status, run_end);
        end
        void'(pending_results.pop_front());
      end
    end
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
  end

  // Watchdog
  initial begin
    #20_000_000;
    timed_out = 1'b1;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int      run_len;
    bit      falling;
    logic    l;
    result_t typed_result;

    rst        = 1'b1;
    in_valid   = 1'b0;
    value      = '0;
    last_value = 1'b0;
    gaps_on    = 1'b1;
    items_sent = 0;
    nge_depth  = 0;
    prev_value = '0;

    // Single values flushed at once, ties, pops up to the extremes, a full
    // stack that drops values, and a flush of a full stack
    dir_rows = '{
      '{value: 32'sd5,   last: 1'b1, reps: 8'd1,  typed: 1'b1, exp_element: 32'sd5,
        exp_status: ngs_pkg::STATUS_NONE},
      '{value: VAL_MIN,  last: 1'b1, reps: 8'd1,  typed: 1'b1, exp_element: VAL_MIN,
        exp_status: ngs_pkg::STATUS_NONE},
      '{value: VAL_MAX,  last: 1'b1, reps: 8'd1,  typed: 1'b1, exp_element: VAL_MAX,
        exp_status: ngs_pkg::STATUS_NONE},
      '{value: 32'sd0,   last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: 32'sd0,   last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: 32'sd3,   last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: VAL_MIN,  last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: -32'sd1,  last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: VAL_MAX,  last: 1'b1, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: 32'sd7,   last: 1'b0, reps: 8'(DEPTH), typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: 32'sd7,   last: 1'b0, reps: 8'd1,  typed: 1'b1, exp_element: 32'sd7,
        exp_status: ngs_pkg::STATUS_OVERFLOW},
      '{value: VAL_MIN,  last: 1'b0, reps: 8'd1,  typed: 1'b1, exp_element: VAL_MIN,
        exp_status: ngs_pkg::STATUS_OVERFLOW},
      '{value: 32'sd6,   last: 1'b1, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: -32'sd2,  last: 1'b0, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND},
      '{value: 32'sd9,   last: 1'b1, reps: 8'd1,  typed: 1'b0, exp_element: 32'sd0,
        exp_status: ngs_pkg::STATUS_FOUND}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      typed_result = '{element: dir_rows[i].exp_element, greater: 32'sd0,
                       status: dir_rows[i].exp_status, run_end: 1'b1};
      for (int k = 0; k < int'(dir_rows[i].reps); k++)
        transfer_value(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, typed_result);
    end

    // Random runs: mostly terminated sequences, some long non-increasing
    // ones to fill the stack, with stray or missing last marks as noise
    while (items_sent < TOTAL_ITEMS) begin
      falling = ($urandom_range(0, 9) < 2);
      run_len = falling ? $urandom_range(34, 40) : $urandom_range(1, 12);
      prev_value = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      for (int k = 0; k < run_len; k++) begin
        gaps_on = !(items_sent >= 160 && items_sent < 240);
        if (falling) begin
          prev_value = prev_value - $signed(32'($urandom_range(0, 3)));
        end
        l = (k == run_len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 4);
        transfer_value(falling ? prev_value : pick_value(), l, 1'b0, '0);
      end
    end
    gaps_on = 1'b1;
    @(posedge clk);
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 20) @(posedge clk);

    $display("Sent %0d values; checked %0d results (%0d pairs, %0d flushed, %0d overflows)",
             items_sent, results_seen, pairs_seen, flushes_seen, overflows_seen);
    $display("Mismatches: %0d, results still expected: %0d", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0 && !timed_out) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
